[design/range_sum_segment_tree_defines.svh]
// range_sum_segment_tree_defines.svh: assertion macros for the range sum tree
// expects signals clk and arst_n in the module that uses them
`ifndef RANGE_SUM_SEGMENT_TREE_DEFINES_SVH
`define RANGE_SUM_SEGMENT_TREE_DEFINES_SVH
`ifndef SYNTHESIS
`define RSST_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`define RSST_ASSERT_NXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define RSST_ASSERT_IMP(label, pre, post, msg)
`define RSST_ASSERT_NXT(label, pre, post, msg)
`endif
`endif

[design/rsst_pkg.sv]
// rsst_pkg: widths, codes and types shared by the range sum tree modules
// no dependencies
`timescale 1ns / 1ps

package rsst_pkg;

	localparam int POS_W = 11;
	localparam int VAL_W = 32;
	localparam int SUM_W = 42;

	localparam logic [POS_W-1:0] CNT_RESET = 11'd1024;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_UP_LEAF,
		S_UP_WALK,
		S_Q_LEFT,
		S_Q_RIGHT,
		S_OUT
	} seq_state_t;

	typedef struct packed {
		logic                    cmd;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        range_low;
		logic [POS_W-1:0]        range_high;
	} item_t;

	typedef struct packed {
		logic                    valid;
		logic signed [SUM_W-1:0] sum;
	} res_t;

endpackage

[design/rsst_mem.sv]
// rsst_mem: node store of the tree, one write port and one read port
// read data registered; uses rsst_pkg for the data width
`timescale 1ns / 1ps

module rsst_mem
	import rsst_pkg::*;
#(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [ADDR_W-1:0]       waddr,
	input  logic signed [SUM_W-1:0] wdata,
	input  logic                    re,
	input  logic [ADDR_W-1:0]       raddr,
	output logic signed [SUM_W-1:0] rdata
);

	logic signed [SUM_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/rsst_seq.sv]
// rsst_seq: sequencer that clears the node store, walks update paths and query spans
// uses rsst_pkg and the assertion macros; drives the ports of rsst_mem
`timescale 1ns / 1ps
`include "range_sum_segment_tree_defines.svh"

module rsst_seq
	import rsst_pkg::*;
#(
	parameter int MAX_ELEMENTS = 1024,
	parameter int NODE_W       = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [POS_W-1:0]        count,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  item_t                   item,
	output res_t                    res,
	input  logic                    res_ready,
	output logic                    mem_we,
	output logic [NODE_W-1:0]       mem_waddr,
	output logic signed [SUM_W-1:0] mem_wdata,
	output logic                    mem_re,
	output logic [NODE_W-1:0]       mem_raddr,
	input  logic signed [SUM_W-1:0] mem_rdata
);

	localparam int IDX_W = NODE_W + 1;
	localparam int CAP_I = (MAX_ELEMENTS > 2047) ? 2047 : MAX_ELEMENTS;
	localparam logic [POS_W-1:0]  CNT_CAP  = POS_W'(CAP_I);
	localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(2 * MAX_ELEMENTS - 1);

	seq_state_t state_q, state_d;

	logic [NODE_W-1:0]       clr_q;
	logic                    pend_q;
	logic [NODE_W-1:0]       node_q;
	logic signed [SUM_W-1:0] cur_q;
	logic [IDX_W-1:0]        l_q, r_q;
	logic signed [SUM_W-1:0] acc_q;

	logic [POS_W-1:0]        count_eff;
	logic                    upd_ok;
	logic [POS_W-1:0]        lo_c, hi_c;
	logic                    q_empty;
	logic                    accept;
	logic [NODE_W-1:0]       leaf;
	logic [IDX_W-1:0]        l_init, r_init;
	logic signed [SUM_W-1:0] walk_sum;

	// clip the span and check the position against the active count
	always_comb begin
		count_eff = (count > CNT_CAP) ? CNT_CAP : count;
		upd_ok    = (item.position != '0) && (item.position <= count_eff);
		lo_c      = (item.range_low == '0) ? POS_W'(1) : item.range_low;
		hi_c      = (item.range_high > count_eff) ? count_eff : item.range_high;
		q_empty   = lo_c > hi_c;
		leaf      = NODE_W'(MAX_ELEMENTS - 1) + NODE_W'(item.position);
		l_init    = IDX_W'(MAX_ELEMENTS - 1) + IDX_W'(lo_c);
		r_init    = IDX_W'(MAX_ELEMENTS) + IDX_W'(hi_c);
		accept    = in_valid && in_ready;
		walk_sum  = cur_q + mem_rdata;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_NODE) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (item.cmd == CMD_UPDATE) begin
						state_d = upd_ok ? S_UP_LEAF : S_IDLE;
					end else begin
						state_d = q_empty ? S_OUT : S_Q_LEFT;
					end
				end
			end
			S_UP_LEAF: state_d = S_UP_WALK;
			S_UP_WALK: begin
				if (node_q == NODE_W'(1)) state_d = S_IDLE;
			end
			S_Q_LEFT:  state_d = (l_q < r_q) ? S_Q_RIGHT : S_OUT;
			S_Q_RIGHT: state_d = S_Q_LEFT;
			S_OUT: begin
				if (res_ready) state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		res.valid = 1'b0;
		res.sum   = acc_q;
		mem_we    = 1'b0;
		mem_waddr = node_q;
		mem_wdata = cur_q;
		mem_re    = 1'b0;
		mem_raddr = node_q ^ NODE_W'(1);
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_IDLE: in_ready = 1'b1;
			S_UP_LEAF: begin
				mem_we = 1'b1;
				mem_re = 1'b1;
			end
			S_UP_WALK: begin
				// parent takes the new child sum plus the sibling just read
				mem_we    = 1'b1;
				mem_wdata = walk_sum;
				mem_re    = node_q != NODE_W'(1);
			end
			S_Q_LEFT: begin
				mem_re    = (l_q < r_q) && l_q[0];
				mem_raddr = l_q[NODE_W-1:0];
			end
			S_Q_RIGHT: begin
				mem_re    = r_q[0];
				mem_raddr = NODE_W'(r_q - 1'b1);
			end
			S_OUT: res.valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= mem_re;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					node_q <= leaf;
					cur_q  <= {{(SUM_W - VAL_W){item.value[VAL_W-1]}}, item.value};
					l_q    <= l_init;
					r_q    <= r_init;
				end
			end
			S_UP_LEAF: node_q <= node_q >> 1;
			S_UP_WALK: begin
				cur_q  <= walk_sum;
				node_q <= node_q >> 1;
			end
			S_Q_LEFT: begin
				if ((l_q < r_q) && l_q[0]) l_q <= l_q + 1'b1;
			end
			S_Q_RIGHT: begin
				l_q <= l_q >> 1;
				r_q <= r_q >> 1;
			end
			default: ;
		endcase
		// read data from the previous cycle folds into the running sum
		if (state_q == S_IDLE) begin
			acc_q <= '0;
		end else if (pend_q) begin
			acc_q <= acc_q + mem_rdata;
		end
	end

	`RSST_ASSERT_IMP(a_span_order, state_q == S_Q_LEFT, l_q <= r_q, "query span crossed over")
	`RSST_ASSERT_IMP(a_pend_state, pend_q, state_q == S_Q_LEFT || state_q == S_Q_RIGHT || state_q == S_UP_WALK, "read data arrived outside a walk")
	`RSST_ASSERT_IMP(a_no_node0, mem_we && state_q != S_CLEAR, mem_waddr != '0, "walk wrote unused node zero")
	`RSST_ASSERT_NXT(a_walk_end, state_q == S_UP_WALK && node_q == NODE_W'(1), state_q == S_IDLE, "update did not finish at the root")

endmodule

[design/range_sum_segment_tree.sv]
// range_sum_segment_tree: point update, range sum segment tree over a node memory
// depends on rsst_pkg, rsst_seq and rsst_mem
`timescale 1ns / 1ps
//
// channel  | handshake             | payload
// ---------+-----------------------+----------------------------------------------
// in       | in_valid / in_ready   | cmd, position, value, range_low, range_high
// out      | out_valid / out_ready | range_sum
// cfg      | cfg_we                | cfg_wdata (element_count)
//
// update: one tree level per cycle (one sibling read and one parent write on the
// node memory ports). query: each level passes through S_Q_LEFT and S_Q_RIGHT,
// as the single read port fetches up to two nodes per level.
// after reset a clearing pass writes zeros to all 2 * MAX_ELEMENTS nodes, one per
// cycle; in_ready stays low until it ends. a result waits in the output register
// while the next item is taken; a second result holds the sequencer until it frees.

module range_sum_segment_tree
	import rsst_pkg::*;
#(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [POS_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    cmd,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	input  logic [POS_W-1:0]        range_low,
	input  logic [POS_W-1:0]        range_high,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [SUM_W-1:0] range_sum
);

	localparam int DEPTH  = 2 * MAX_ELEMENTS;
	localparam int NODE_W = $clog2(DEPTH);

	logic [POS_W-1:0]        count_q;
	logic                    out_valid_q;
	logic signed [SUM_W-1:0] range_sum_q;

	item_t                   item;
	res_t                    res;
	logic                    res_ready;
	logic                    mem_we, mem_re;
	logic [NODE_W-1:0]       mem_waddr, mem_raddr;
	logic signed [SUM_W-1:0] mem_wdata, mem_rdata;

	always_comb begin
		item.cmd        = cmd;
		item.position   = position;
		item.value      = value;
		item.range_low  = range_low;
		item.range_high = range_high;
		res_ready       = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CNT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) count_q <= cfg_wdata;
			if (res_ready) out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) range_sum_q <= res.sum;
	end

	assign out_valid = out_valid_q;
	assign range_sum = range_sum_q;

	rsst_seq #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.NODE_W       (NODE_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.count     (count_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.item      (item),
		.res       (res),
		.res_ready (res_ready),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	rsst_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (NODE_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
